// File: src/srp_pkg.sv
// Shared types and constants for the smoothed ramp profile block.
package srp_pkg;

    localparam int unsigned CFG_IDX_BITS = 8;

    localparam logic [CFG_IDX_BITS-1:0] CFG_RAMP_START = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RAMP_END   = 8'd1;

    localparam int unsigned RAMP_END_RESET = 1000;

    typedef enum logic [2:0] {
        MODE_ZERO,
        MODE_FULL,
        MODE_LIN,
        MODE_BLEND_S,
        MODE_BLEND_E
    } mode_t;

endpackage

// File: src/smoothed_ramp_profile.sv
// Smoothed ramp profile: linear ramp with parabolic corner blends, fully pipelined.
//
// Each request on s_axis carries one signed time sample; the block returns one
// unsigned Q(FRAC_BITS) profile value on m_axis (2^FRAC_BITS stands for one).
// One sample is taken per clock while the pipe advances. Five stages compute
// the differences, window tests, squares and the dividend/divisor, then a
// restoring divider retires one quotient bit per stage over FRAC_BITS + 1
// stages, and an output register holds the result. The whole pipe advances when
// the output register is empty or being taken. ramp_start (index 0) and ramp_end
// (index 1) are written on the cfg port; the user must write them only while the
// pipe is empty, as the block does not enforce it. Other indexes are ignored.
module smoothed_ramp_profile #(
    parameter int unsigned TIME_BITS = 32,
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // sample_time [TIME_BITS-1:0]
    input  logic [((TIME_BITS+7)/8)*8-1:0]        s_axis_tdata,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // ramp_value [FRAC_BITS:0]
    output logic [((FRAC_BITS+8)/8)*8-1:0]        m_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [srp_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [TIME_BITS-1:0]                  cfg_data
);

    localparam int unsigned TB  = TIME_BITS;
    localparam int unsigned FB  = FRAC_BITS;
    localparam int unsigned OB  = FB + 1;
    localparam int unsigned OW  = ((FB + 8) / 8) * 8;
    localparam int unsigned WB  = TB + 1;
    localparam int unsigned XW  = TB + 6;
    localparam int unsigned WLO = WB / 2;
    localparam int unsigned WHI = WB - WLO;
    localparam int unsigned LLO = TB / 2;
    localparam int unsigned LHI = TB - LLO;
    localparam int unsigned RW  = 2 * TB + FB + 8;
    localparam int unsigned Q   = FB + 1;

    localparam logic [OB-1:0] ONE_Q = OB'(1) << FB;

    // configuration
    logic [TB-1:0] start_reg;
    logic [TB-1:0] end_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            end_reg   <= TB'(srp_pkg::RAMP_END_RESET);
        end
        else if (cfg_valid)
        begin
            if (cfg_index == srp_pkg::CFG_RAMP_START)
            begin
                start_reg <= cfg_data;
            end
            else if (cfg_index == srp_pkg::CFG_RAMP_END)
            begin
                end_reg <= cfg_data;
            end
        end
    end

    logic en;
    logic out_vld_reg;

    assign en            = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = en;

    // stage 1: differences
    logic                 s1_vld_reg;
    logic signed [TB:0]   s1_dt_reg;
    logic signed [TB:0]   s1_de_reg;
    logic signed [TB:0]   s1_len_reg;
    logic [TB-1:0]        s1_a_reg;
    logic signed [TB:0]   t_ext;
    logic signed [TB:0]   a_ext;
    logic signed [TB:0]   b_ext;

    assign t_ext = $signed({s_axis_tdata[TB-1], s_axis_tdata[TB-1:0]});
    assign a_ext = $signed({start_reg[TB-1], start_reg});
    assign b_ext = $signed({end_reg[TB-1], end_reg});

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_dt_reg  <= t_ext - a_ext;
            s1_de_reg  <= t_ext - b_ext;
            s1_len_reg <= b_ext - a_ext;
            s1_a_reg   <= start_reg;
        end
    end

    // stage 2: scaled window tests, mode and blend offset
    logic                 s2_vld_reg;
    srp_pkg::mode_t       s2_mode_reg;
    logic [WB-1:0]        s2_w_reg;
    logic [TB-1:0]        s2_len_reg;
    srp_pkg::mode_t       s2_mode_next;
    logic [WB-1:0]        s2_w_next;
    logic signed [XW-1:0] dtx;
    logic signed [XW-1:0] dex;
    logic signed [XW-1:0] lenx;
    logic signed [XW-1:0] nlenx;
    logic signed [XW-1:0] ax;
    logic signed [XW-1:0] sd;
    logic signed [XW-1:0] ed;
    logic signed [XW-1:0] sa20;
    logic signed [XW-1:0] u_full;
    logic signed [XW-1:0] v_full;
    logic                 len_pos;
    logic                 start_blend;
    logic                 end_blend;

    assign dtx   = $signed({{5{s1_dt_reg[TB]}}, s1_dt_reg});
    assign dex   = $signed({{5{s1_de_reg[TB]}}, s1_de_reg});
    assign lenx  = $signed({{5{s1_len_reg[TB]}}, s1_len_reg});
    assign nlenx = -lenx;
    assign ax    = $signed({{6{s1_a_reg[TB-1]}}, s1_a_reg});
    assign sd    = (dtx <<< 4) + (dtx <<< 2);
    assign ed    = (dex <<< 4) + (dex <<< 2);
    assign sa20  = (ax <<< 4) + (ax <<< 2);
    assign u_full = sd + lenx;
    assign v_full = lenx - ed;

    assign len_pos     = !s1_len_reg[TB] && (s1_len_reg != '0);
    assign start_blend = len_pos && (sd > nlenx) && (sd < lenx) && (sa20 > lenx);
    assign end_blend   = len_pos && (ed > nlenx) && (ed < lenx);

    always_comb
    begin
        s2_w_next = s1_dt_reg[TB:0];
        if (!len_pos)
        begin
            s2_mode_next = s1_dt_reg[TB] ? srp_pkg::MODE_ZERO : srp_pkg::MODE_FULL;
        end
        else if (end_blend)
        begin
            s2_mode_next = srp_pkg::MODE_BLEND_E;
            s2_w_next    = v_full[WB-1:0];
        end
        else if (start_blend)
        begin
            s2_mode_next = srp_pkg::MODE_BLEND_S;
            s2_w_next    = u_full[WB-1:0];
        end
        else if (s1_dt_reg[TB])
        begin
            s2_mode_next = srp_pkg::MODE_ZERO;
        end
        else if (s1_de_reg[TB])
        begin
            s2_mode_next = srp_pkg::MODE_LIN;
        end
        else
        begin
            s2_mode_next = srp_pkg::MODE_FULL;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_mode_reg <= s2_mode_next;
            s2_w_reg    <= s2_w_next;
            s2_len_reg  <= s1_len_reg[TB-1:0];
        end
    end

    // stage 3: partial products of w^2 and L^2
    logic                 s3_vld_reg;
    srp_pkg::mode_t       s3_mode_reg;
    logic [WB-1:0]        s3_w_reg;
    logic [TB-1:0]        s3_len_reg;
    logic [WB+WLO-1:0]    s3_pw_lo_reg;
    logic [WB+WHI-1:0]    s3_pw_hi_reg;
    logic [TB+LLO-1:0]    s3_pl_lo_reg;
    logic [TB+LHI-1:0]    s3_pl_hi_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_mode_reg  <= s2_mode_reg;
            s3_w_reg     <= s2_w_reg;
            s3_len_reg   <= s2_len_reg;
            s3_pw_lo_reg <= (WB+WLO)'(s2_w_reg) * (WB+WLO)'(s2_w_reg[WLO-1:0]);
            s3_pw_hi_reg <= (WB+WHI)'(s2_w_reg) * (WB+WHI)'(s2_w_reg[WB-1:WLO]);
            s3_pl_lo_reg <= (TB+LLO)'(s2_len_reg) * (TB+LLO)'(s2_len_reg[LLO-1:0]);
            s3_pl_hi_reg <= (TB+LHI)'(s2_len_reg) * (TB+LHI)'(s2_len_reg[TB-1:LLO]);
        end
    end

    // stage 4: squares
    logic                 s4_vld_reg;
    srp_pkg::mode_t       s4_mode_reg;
    logic [WB-1:0]        s4_w_reg;
    logic [TB-1:0]        s4_len_reg;
    logic [2*WB-1:0]      s4_sqw_reg;
    logic [2*TB-1:0]      s4_sql_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_mode_reg <= s3_mode_reg;
            s4_w_reg    <= s3_w_reg;
            s4_len_reg  <= s3_len_reg;
            s4_sqw_reg  <= (2*WB)'(s3_pw_lo_reg) + ((2*WB)'(s3_pw_hi_reg) << WLO);
            s4_sql_reg  <= (2*TB)'(s3_pl_lo_reg) + ((2*TB)'(s3_pl_hi_reg) << LLO);
        end
    end

    // stage 5: dividend and divisor
    logic                 s5_vld_reg;
    srp_pkg::mode_t       s5_mode_reg;
    logic [RW-1:0]        s5_num_reg;
    logic [RW-1:0]        s5_den_reg;
    logic [RW-1:0]        l80;
    logic [RW-1:0]        num_next;
    logic [RW-1:0]        den_next;
    logic                 is_blend;

    assign l80      = (RW'(s4_sql_reg) << 6) + (RW'(s4_sql_reg) << 4);
    assign is_blend = (s4_mode_reg == srp_pkg::MODE_BLEND_S) ||
                      (s4_mode_reg == srp_pkg::MODE_BLEND_E);

    always_comb
    begin
        if (is_blend)
        begin
            num_next = (RW'(s4_sqw_reg) << (FB + 1)) + l80;
            den_next = l80 << 1;
        end
        else
        begin
            num_next = (RW'(s4_w_reg) << (FB + 1)) + RW'(s4_len_reg);
            den_next = RW'(s4_len_reg) << 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_mode_reg <= s4_mode_reg;
            s5_num_reg  <= num_next;
            s5_den_reg  <= den_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_vld_reg <= s_axis_tvalid;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_vld_reg;
        end
    end

    // restoring divider, one quotient bit per stage, MSB first
    logic                 dv_vld_reg  [Q];
    srp_pkg::mode_t       dv_mode_reg [Q];
    logic [Q-1:0]         dv_q_reg    [Q];
    logic [RW-1:0]        dv_rem_reg  [Q-1];
    logic [RW-1:0]        dv_den_reg  [Q-1];

    for (genvar k = 0; k < Q; k++)
    begin : g_div
        localparam int unsigned SH = Q - 1 - k;

        logic           vld_in;
        srp_pkg::mode_t mode_in;
        logic [Q-1:0]   q_in;
        logic [RW-1:0]  rem_in;
        logic [RW-1:0]  den_in;
        logic [RW-1:0]  den_sh;
        logic           ge;

        if (k == 0)
        begin : g_first
            assign vld_in  = s5_vld_reg;
            assign mode_in = s5_mode_reg;
            assign q_in    = '0;
            assign rem_in  = s5_num_reg;
            assign den_in  = s5_den_reg;
        end
        else
        begin : g_next
            assign vld_in  = dv_vld_reg[k-1];
            assign mode_in = dv_mode_reg[k-1];
            assign q_in    = dv_q_reg[k-1];
            assign rem_in  = dv_rem_reg[k-1];
            assign den_in  = dv_den_reg[k-1];
        end

        assign den_sh = den_in << SH;
        assign ge     = rem_in >= den_sh;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                dv_vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_mode_reg[k] <= mode_in;
                dv_q_reg[k]    <= {q_in[Q-2:0], ge};
            end
        end

        if (k < Q - 1)
        begin : g_rem
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dv_rem_reg[k] <= ge ? (rem_in - den_sh) : rem_in;
                    dv_den_reg[k] <= den_in;
                end
            end
        end
    end

    // output register
    logic [OB-1:0] out_val_reg;
    logic [OB-1:0] out_val_next;
    logic [OB-1:0] quo;

    assign quo = dv_q_reg[Q-1][OB-1:0];

    always_comb
    begin
        case (dv_mode_reg[Q-1])
            srp_pkg::MODE_ZERO:    out_val_next = '0;
            srp_pkg::MODE_FULL:    out_val_next = ONE_Q;
            srp_pkg::MODE_BLEND_E: out_val_next = ONE_Q - quo;
            default:               out_val_next = quo;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= dv_vld_reg[Q-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_val_reg <= out_val_next;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = OW'(out_val_reg);

endmodule
